// ----- hdl/cubic_bezier_to_quadratics_unit_defines.svh -----
// Assertion macros for the cubic to quadratic subdivision block.
`ifndef CUBIC_BEZIER_TO_QUADRATICS_UNIT_DEFINES_SVH
`define CUBIC_BEZIER_TO_QUADRATICS_UNIT_DEFINES_SVH
// Assert that an implication holds on every clock edge outside reset.
`define CBQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert that a signal never carries an unknown value outside reset.
`define CBQ_ASSERT_KNOWN(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) else $error(msg);
`endif

// ----- hdl/cbq_pkg.sv -----
// ----------------------------------------------------------------------------
// cbq_pkg
// Types, constants and arithmetic helpers of the cubic to quadratic block.
// ----------------------------------------------------------------------------
`default_nettype none
package cbq_pkg;

  localparam int unsigned MaxLevels = 4;
  localparam int unsigned LvlW = 3;
  localparam int unsigned StackDepth = MaxLevels + 1;
  localparam int unsigned SpW = 3;
  localparam int unsigned TolW = 31;
  localparam logic [TolW-1:0] TolReset = 31'd16384;
  localparam logic [8:0] ErrRatio = 9'd432;

  typedef struct packed {
    logic signed [31:0] p0_x;
    logic signed [31:0] p0_y;
    logic signed [31:0] p1_x;
    logic signed [31:0] p1_y;
    logic signed [31:0] p2_x;
    logic signed [31:0] p2_y;
    logic signed [31:0] p3_x;
    logic signed [31:0] p3_y;
  } cubic_t;

  typedef struct packed {
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_ctrl_x;
    logic signed [31:0] seg_ctrl_y;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
    logic [4:0]         segment_total;
    logic               last;
  } quad_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_SQX, ST_SQY, ST_SUM, ST_TOLSQ, ST_BASE, ST_CMP,
    ST_POP, ST_SPLIT, ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic diff;
    logic sqx;
    logic sqy;
    logic sum;
    logic tolsq;
    logic base;
    logic cmp;
    logic pop;
    logic split;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic            fits;
    logic            tol_zero;
    logic [LvlW-1:0] cmp_lvl;
    logic [LvlW-1:0] cur_lvl;
    logic            last_leaf;
  } status_t;

  function automatic logic signed [31:0] half_sum(logic signed [31:0] a,
                                                  logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    return s[32:1];
  endfunction

  function automatic logic signed [31:0] ctrl_pt(logic signed [31:0] p0,
                                                 logic signed [31:0] p1,
                                                 logic signed [31:0] p2,
                                                 logic signed [31:0] p3);
    logic signed [35:0] s;
    logic signed [33:0] q;
    s = 36'sd3 * (36'(p1) + 36'(p2)) - 36'(p0) - 36'(p3);
    q = s[35:2];
    if (q > 34'sd2147483647) return 32'sh7fffffff;
    if (q < -34'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/cbq_ctrl.sv -----
// ----------------------------------------------------------------------------
// cbq_ctrl
// Sequencer: level choice, depth-first split walk and result emission.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cubic_bezier_to_quadratics_unit_defines.svh"
module cbq_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire cbq_pkg::status_t status_i,
  output cbq_pkg::cmd_t         cmd_o,
  output logic                  busy_o
);

  cbq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    busy_o = (state_q != cbq_pkg::ST_IDLE);
    case (state_q)
      cbq_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = cbq_pkg::ST_DIFF;
        end
      end
      cbq_pkg::ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d = cbq_pkg::ST_SQX;
      end
      cbq_pkg::ST_SQX: begin
        cmd_o.sqx = 1'b1;
        state_d = cbq_pkg::ST_SQY;
      end
      cbq_pkg::ST_SQY: begin
        cmd_o.sqy = 1'b1;
        state_d = cbq_pkg::ST_SUM;
      end
      cbq_pkg::ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d = cbq_pkg::ST_TOLSQ;
      end
      cbq_pkg::ST_TOLSQ: begin
        cmd_o.tolsq = 1'b1;
        state_d = cbq_pkg::ST_BASE;
      end
      cbq_pkg::ST_BASE: begin
        cmd_o.base = 1'b1;
        state_d = cbq_pkg::ST_CMP;
      end
      cbq_pkg::ST_CMP: begin
        cmd_o.cmp = 1'b1;
        if (status_i.tol_zero || status_i.fits ||
            status_i.cmp_lvl == cbq_pkg::LvlW'(cbq_pkg::MaxLevels)) begin
          state_d = cbq_pkg::ST_POP;
        end
      end
      cbq_pkg::ST_POP: begin
        cmd_o.pop = 1'b1;
        state_d = cbq_pkg::ST_SPLIT;
      end
      cbq_pkg::ST_SPLIT: begin
        if (status_i.cur_lvl != '0) begin
          cmd_o.split = 1'b1;
        end else begin
          state_d = cbq_pkg::ST_EMIT;
        end
      end
      cbq_pkg::ST_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d = status_i.last_leaf ? cbq_pkg::ST_IDLE : cbq_pkg::ST_POP;
      end
      default: state_d = cbq_pkg::ST_IDLE;
    endcase
  end

  `CBQ_ASSERT(a_load_idle, clk_i, rst_ni, cmd_o.load |-> state_q == cbq_pkg::ST_IDLE, "load outside idle")
  `CBQ_ASSERT(a_split_lvl, clk_i, rst_ni, cmd_o.split |-> status_i.cur_lvl != '0, "split at leaf")
  `CBQ_ASSERT(a_emit_ret, clk_i, rst_ni, (cmd_o.emit && status_i.last_leaf) |=> !busy_o, "no return to idle")

endmodule
`default_nettype wire

// ----- hdl/cbq_datapath.sv -----
// ----------------------------------------------------------------------------
// cbq_datapath
// Error metric, split stack, midpoint splitter and control point unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cubic_bezier_to_quadratics_unit_defines.svh"
module cbq_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire cbq_pkg::cmd_t                  cmd_i,
  input  wire cbq_pkg::cubic_t                cubic_i,
  input  wire logic [cbq_pkg::TolW-1:0]       tol_i,
  output cbq_pkg::status_t                    status_o,
  output cbq_pkg::quad_t                      quad_o,
  output logic                                valid_o
);

  cbq_pkg::cubic_t cur_q;
  logic [cbq_pkg::LvlW-1:0] cur_lvl_q;
  logic signed [34:0] dx_q, dy_q;
  logic [33:0] ax_q, ay_q;
  logic [67:0] sqx_q, sqy_q;
  logic [68:0] lhs_q;
  logic [61:0] tsq_q;
  logic [70:0] base_q;
  logic [cbq_pkg::LvlW-1:0] lvl_q, L_q;
  logic tol_zero_q;
  logic [cbq_pkg::SpW-1:0] sp_q;
  logic [4:0] n_q;
  logic signed [31:0] sx_q, sy_q;
  cbq_pkg::quad_t quad_q;
  logic valid_q;

  cbq_pkg::cubic_t stack_mem [cbq_pkg::StackDepth];
  logic [cbq_pkg::LvlW-1:0] lvl_mem [cbq_pkg::StackDepth];

  cbq_pkg::cubic_t lft, rgt;
  logic [94:0] thr;
  logic [4:0] total;
  logic signed [31:0] a01x, a12x, a23x, a012x, a123x, mx;
  logic signed [31:0] a01y, a12y, a23y, a012y, a123y, my;
  logic [cbq_pkg::SpW-1:0] sp_m1;

  assign sp_m1 = sp_q - 1'b1;
  assign total = 5'd1 << L_q;
  assign thr = 95'(base_q) << (6 * lvl_q);

  always_comb begin
    a01x = cbq_pkg::half_sum(cur_q.p0_x, cur_q.p1_x);
    a12x = cbq_pkg::half_sum(cur_q.p1_x, cur_q.p2_x);
    a23x = cbq_pkg::half_sum(cur_q.p2_x, cur_q.p3_x);
    a012x = cbq_pkg::half_sum(a01x, a12x);
    a123x = cbq_pkg::half_sum(a12x, a23x);
    mx = cbq_pkg::half_sum(a012x, a123x);
    a01y = cbq_pkg::half_sum(cur_q.p0_y, cur_q.p1_y);
    a12y = cbq_pkg::half_sum(cur_q.p1_y, cur_q.p2_y);
    a23y = cbq_pkg::half_sum(cur_q.p2_y, cur_q.p3_y);
    a012y = cbq_pkg::half_sum(a01y, a12y);
    a123y = cbq_pkg::half_sum(a12y, a23y);
    my = cbq_pkg::half_sum(a012y, a123y);
    lft = '{cur_q.p0_x, cur_q.p0_y, a01x, a01y, a012x, a012y, mx, my};
    rgt = '{mx, my, a123x, a123y, a23x, a23y, cur_q.p3_x, cur_q.p3_y};
  end

  always_comb begin
    status_o.fits = ({26'd0, lhs_q} <= thr);
    status_o.tol_zero = tol_zero_q;
    status_o.cmp_lvl = lvl_q;
    status_o.cur_lvl = cur_lvl_q;
    status_o.last_leaf = (n_q + 5'd1 == total);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q <= cubic_i;
      tol_zero_q <= (tol_i == '0);
    end
    if (cmd_i.diff) begin
      dx_q <= 35'(cur_q.p3_x) - 35'(cur_q.p0_x) + 35'sd3 * (35'(cur_q.p1_x) - 35'(cur_q.p2_x));
      dy_q <= 35'(cur_q.p3_y) - 35'(cur_q.p0_y) + 35'sd3 * (35'(cur_q.p1_y) - 35'(cur_q.p2_y));
    end
    if (cmd_i.sqx) begin
      ax_q <= dx_q[34] ? 34'(-dx_q) : dx_q[33:0];
      ay_q <= dy_q[34] ? 34'(-dy_q) : dy_q[33:0];
    end
    if (cmd_i.sqy) begin
      sqx_q <= ax_q * ax_q;
      sqy_q <= ay_q * ay_q;
    end
    if (cmd_i.sum) lhs_q <= 69'(sqx_q) + 69'(sqy_q);
    if (cmd_i.tolsq) tsq_q <= 62'(tol_i) * 62'(tol_i);
    if (cmd_i.base) base_q <= 71'(tsq_q) * 71'(cbq_pkg::ErrRatio);
    if (cmd_i.split) begin
      cur_q <= lft;
      cur_lvl_q <= cur_lvl_q - 1'b1;
      stack_mem[sp_q] <= rgt;
      lvl_mem[sp_q] <= cur_lvl_q - 1'b1;
    end
    if (cmd_i.pop) begin
      cur_q <= stack_mem[sp_m1];
      cur_lvl_q <= lvl_mem[sp_m1];
    end
    if (cmd_i.cmp && (tol_zero_q || status_o.fits ||
        lvl_q == cbq_pkg::LvlW'(cbq_pkg::MaxLevels))) begin
      stack_mem[0] <= cur_q;
      lvl_mem[0] <= tol_zero_q ? '0 : lvl_q;
      L_q <= tol_zero_q ? '0 : lvl_q;
      sx_q <= cur_q.p0_x;
      sy_q <= cur_q.p0_y;
    end
    if (cmd_i.emit) begin
      quad_q.seg_start_x <= sx_q;
      quad_q.seg_start_y <= sy_q;
      quad_q.seg_ctrl_x <= cbq_pkg::ctrl_pt(cur_q.p0_x, cur_q.p1_x, cur_q.p2_x, cur_q.p3_x);
      quad_q.seg_ctrl_y <= cbq_pkg::ctrl_pt(cur_q.p0_y, cur_q.p1_y, cur_q.p2_y, cur_q.p3_y);
      quad_q.seg_end_x <= cur_q.p3_x;
      quad_q.seg_end_y <= cur_q.p3_y;
      quad_q.segment_total <= total;
      quad_q.last <= status_o.last_leaf;
      sx_q <= cur_q.p3_x;
      sy_q <= cur_q.p3_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= '0;
      sp_q <= '0;
      n_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
      if (cmd_i.load) begin
        lvl_q <= '0;
        n_q <= '0;
      end
      if (cmd_i.cmp) begin
        if (tol_zero_q || status_o.fits ||
            lvl_q == cbq_pkg::LvlW'(cbq_pkg::MaxLevels)) begin
          sp_q <= cbq_pkg::SpW'(1);
        end else begin
          lvl_q <= lvl_q + 1'b1;
        end
      end
      if (cmd_i.pop) sp_q <= sp_m1;
      if (cmd_i.split) sp_q <= sp_q + 1'b1;
      if (cmd_i.emit) n_q <= n_q + 5'd1;
    end
  end

  assign quad_o = quad_q;
  assign valid_o = valid_q;

  `CBQ_ASSERT(a_sp_range, clk_i, rst_ni, sp_q <= cbq_pkg::SpW'(cbq_pkg::StackDepth), "stack overflow")
  `CBQ_ASSERT(a_pop_nonempty, clk_i, rst_ni, cmd_i.pop |-> sp_q != '0, "pop of empty stack")
  `CBQ_ASSERT(a_emit_count, clk_i, rst_ni, cmd_i.emit |-> n_q < total, "too many segments")

endmodule
`default_nettype wire

// ----- hdl/cubic_bezier_to_quadratics_unit.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_to_quadratics_unit
// Splits one cubic Bezier into 2^L quadratic segments by midpoint subdivision.
// ----------------------------------------------------------------------------
// A cubic is taken when start_i is high and busy_o is low. The level, at most
// four, is chosen by the error-term states DIFF, SQX, SQY, SUM, TOLSQ and BASE
// and then one level test per cycle; then each of the 2^L leaves costs a pop,
// a split for each level left above it, a leaf check and an emit. Each segment
// appears for one cycle with seg_valid_o, and the receiver cannot stall it. The
// tolerance register sits at APB address zero; the user must see that it is
// written only while busy_o is low, as the block itself does not enforce this.
`default_nettype none
module cubic_bezier_to_quadratics_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire cbq_pkg::cubic_t cubic_i,
  output logic                 busy_o,
  output logic                 seg_valid_o,
  output cbq_pkg::quad_t       seg_o,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [1:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [cbq_pkg::TolW-1:0] tol_q;
  cbq_pkg::cmd_t cmd;
  cbq_pkg::status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= cbq_pkg::TolReset;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      tol_q <= pwdata[cbq_pkg::TolW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {1'b0, tol_q} : 32'd0;

  cbq_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .status_i(status), .cmd_o(cmd), .busy_o
  );

  cbq_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .cubic_i, .tol_i(tol_q),
    .status_o(status), .quad_o(seg_o), .valid_o(seg_valid_o)
  );

endmodule
`default_nettype wire
